// ===== hdl/pn3_pkg.sv =====
// Shared types, constants and the permutation ROM of the 3D gradient noise block.
`default_nettype none

package pn3_pkg;

    // Request codes carried by req_type.
    localparam logic REQ_EVAL = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // Corner dot products and blends: three Q1.15 by Q.16 products summed, Q.31.
    localparam int CORNER_W = 35;
    // Smoothstep weight in Q0.16, range 0 to 65536.
    localparam int WEIGHT_W = 17;
    // One gradient entry: x, y and z components of Q1.15 each.
    localparam int GRAD_W   = 48;
    // Output word width, Q2.16.
    localparam int NOISE_W  = 18;

    typedef logic signed [CORNER_W-1:0] corner_t;
    typedef logic [WEIGHT_W-1:0]        weight_t;
    typedef logic [GRAD_W-1:0]          grad_t;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
        return PERM_ROM[idx];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pn3_lerp.sv =====
// Three-stage pipelined linear blend a + floor(w * (b - a) / 2^16).
`default_nettype none

module pn3_lerp
    import pn3_pkg::*;
(
    input  wire logic    clk,
    input  wire corner_t a,
    input  wire corner_t b,
    input  wire weight_t w,
    output corner_t      y
);

    logic signed [CORNER_W:0]            diff_reg;
    corner_t                             a1_reg;
    weight_t                             w1_reg;
    logic signed [CORNER_W+WEIGHT_W+1:0] prod_reg;
    corner_t                             a2_reg;
    corner_t                             y_reg;
    logic signed [CORNER_W+WEIGHT_W+1:0] shifted;

    // The blended value always lies between a and b, so it fits a corner word.
    assign shifted = prod_reg >>> 16;

    always_ff @(posedge clk)
    begin
        diff_reg <= (CORNER_W+1)'(b) - (CORNER_W+1)'(a);
        a1_reg   <= a;
        w1_reg   <= w;
        prod_reg <= $signed({1'b0, w1_reg}) * diff_reg;
        a2_reg   <= a1_reg;
        y_reg    <= a2_reg + shifted[CORNER_W-1:0];
    end

    assign y = y_reg;

endmodule

`default_nettype wire

// ===== hdl/perlin_noise_3d.sv =====
// Top level of the pipelined 3D gradient noise evaluator with loadable gradient table.
// A noise word appears on noise_value with done high once the request has left the last stage.
// Throughput: one request per cycle, evaluate or load, for any mix; busy stays low.
// Load requests occupy one pipeline slot and never raise done.
// Reset clears all valid bits; the gradient table is not cleared and must be loaded first.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`default_nettype none

module perlin_noise_3d
    import pn3_pkg::*;
#(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               req_type,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    input  wire logic signed [31:0] coord_z,
    input  wire logic [7:0]         grad_slot,
    input  wire logic signed [15:0] grad_x,
    input  wire logic signed [15:0] grad_y,
    input  wire logic signed [15:0] grad_z,
    output logic                    done,
    output logic signed [NOISE_W-1:0] noise_value
);

    // Width of a lattice index; the hash wraps modulo TABLE_SIZE.
    localparam int IW = $clog2(TABLE_SIZE);

    // Pipeline map, stages in the order in which a request passes them:
    //   1  lattice indices and Q0.16 fractions split off the coordinates
    //   2  z hash through the permutation ROM, fraction squares
    //   3  y hash, smoothstep weights
    //   4  x hash giving the eight corner gradient addresses
    //   5  gradient reads from eight replicated table copies; loads write here too,
    //      so a load lands in program order relative to every evaluate
    //   6  per-axis gradient times offset products
    //   7  corner dot products
    //   8-10  four x blends, 11-13 two y blends, 14-16 the z blend
    //   17 floor to Q2.16 and saturate into the output word
    localparam int LAST = 17;

    logic accept;
    logic [LAST:1] ev_pipe_reg;
    logic [4:1]    ld_pipe_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_pipe_reg <= '0;
            ld_pipe_reg <= '0;
        end
        else
        begin
            ev_pipe_reg <= {ev_pipe_reg[LAST-1:1], accept && (req_type == REQ_EVAL)};
            ld_pipe_reg <= {ld_pipe_reg[3:1], accept && (req_type == REQ_LOAD)};
        end
    end

    assign done = ev_pipe_reg[LAST];

    // ---------------------------------------------------------------- stage 1
    logic [31:0]    coord [3];
    logic [IW-1:0]  s1_idx_next [3];
    logic [15:0]    s1_t_next [3];
    logic [IW-1:0]  s1_idx_reg [3];
    logic [15:0]    t_reg [1:5][3];
    logic [IW-1:0]  s1_slot_reg, s2_slot_reg, s3_slot_reg, s4_slot_reg;
    grad_t          s1_grad_reg, s2_grad_reg, s3_grad_reg, s4_grad_reg;

    assign coord[0] = coord_x;
    assign coord[1] = coord_y;
    assign coord[2] = coord_z;

    always_comb
    begin
        logic [FRAC_BITS+15:0] fext;
        for (int a = 0; a < 3; a++)
        begin
            // Fraction to Q0.16: extra low bits drop, missing bits fill with zero.
            fext           = {coord[a][FRAC_BITS-1:0], 16'h0000};
            s1_t_next[a]   = fext[FRAC_BITS+15:FRAC_BITS];
            s1_idx_next[a] = coord[a][FRAC_BITS+IW-1:FRAC_BITS];
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic [7:0]     s2_hz_next [2];
    logic [31:0]    s2_tt_next [3];
    logic [7:0]     s2_hz_reg [2];
    logic [31:0]    s2_tt_reg [3];
    logic [IW-1:0]  s2_x0_reg, s2_y0_reg;

    always_comb
    begin
        s2_hz_next[0] = perm_lookup(8'(s1_idx_reg[2]));
        s2_hz_next[1] = perm_lookup(8'(s1_idx_reg[2] + IW'(1)));
        for (int a = 0; a < 3; a++)
        begin
            s2_tt_next[a] = t_reg[1][a] * t_reg[1][a];
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic [7:0]     s3_hyz_next [4];
    weight_t        s3_w_next [3];
    logic [7:0]     s3_hyz_reg [4];
    logic [IW-1:0]  s3_x0_reg;
    weight_t        w_reg [3:13][3];

    always_comb
    begin
        logic [IW-1:0] yj;
        logic [IW-1:0] sum;
        logic [49:0]   prod;
        for (int n = 0; n < 4; n++)
        begin
            // Entry n holds y offset n[1] and z offset n[0].
            yj  = s2_y0_reg + IW'(n / 2);
            sum = yj + s2_hz_reg[n % 2][IW-1:0];
            s3_hyz_next[n] = perm_lookup(8'(sum));
        end
        for (int a = 0; a < 3; a++)
        begin
            // Smoothstep weight t^2 (3 - 2t) in Q0.16, floored.
            prod = 50'(s2_tt_reg[a]) * 50'(18'd196608 - {1'b0, t_reg[2][a], 1'b0});
            s3_w_next[a] = prod[48:32];
        end
    end

    // ---------------------------------------------------------------- stage 4
    logic [IW-1:0]  s4_h_next [8];
    logic [IW-1:0]  s4_h_reg [8];

    always_comb
    begin
        logic [IW-1:0] xi;
        logic [IW-1:0] sum;
        logic [7:0]    h;
        for (int c = 0; c < 8; c++)
        begin
            // Corner c: x offset c[0], y offset c[1], z offset c[2].
            xi  = s3_x0_reg + IW'(c % 2);
            sum = xi + s3_hyz_reg[((c / 2) % 2) * 2 + (c / 4)][IW-1:0];
            h   = perm_lookup(8'(sum));
            s4_h_next[c] = h[IW-1:0];
        end
    end

    // ---------------------------------------------------------------- stage 5
    grad_t s5_g [8];

    for (genvar gc = 0; gc < 8; gc++)
    begin : g_gmem
        grad_t gmem_mem [TABLE_SIZE];
        grad_t rd_reg;

        always_ff @(posedge clk)
        begin
            if (ld_pipe_reg[4])
            begin
                gmem_mem[s4_slot_reg] <= s4_grad_reg;
            end
            rd_reg <= gmem_mem[s4_h_reg[gc]];
        end

        assign s5_g[gc] = rd_reg;
    end

    // ---------------------------------------------------------------- stage 6
    logic signed [32:0] s6_p_next [8][3];
    logic signed [32:0] s6_p_reg [8][3];

    always_comb
    begin
        logic signed [15:0] g;
        logic               far;
        for (int c = 0; c < 8; c++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                g   = s5_g[c][GRAD_W-1-16*a -: 16];
                far = c[a];
                // Offset is t for the near corner and t - 1 for the far one.
                s6_p_next[c][a] = g * $signed({far, t_reg[5][a]});
            end
        end
    end

    // ---------------------------------------------------------------- stage 7
    corner_t s7_c_next [8];
    corner_t s7_c_reg [8];

    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            s7_c_next[c] = CORNER_W'(s6_p_reg[c][0]) + CORNER_W'(s6_p_reg[c][1])
                         + CORNER_W'(s6_p_reg[c][2]);
        end
    end

    // ---------------------------------------------------------------- payload regs
    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= s1_idx_next;
        t_reg[1]    <= s1_t_next;
        s1_slot_reg <= grad_slot[IW-1:0];
        s1_grad_reg <= {grad_x, grad_y, grad_z};

        s2_hz_reg   <= s2_hz_next;
        s2_tt_reg   <= s2_tt_next;
        s2_x0_reg   <= s1_idx_reg[0];
        s2_y0_reg   <= s1_idx_reg[1];
        s2_slot_reg <= s1_slot_reg;
        s2_grad_reg <= s1_grad_reg;

        s3_hyz_reg  <= s3_hyz_next;
        s3_x0_reg   <= s2_x0_reg;
        w_reg[3]    <= s3_w_next;
        s3_slot_reg <= s2_slot_reg;
        s3_grad_reg <= s2_grad_reg;

        s4_h_reg    <= s4_h_next;
        s4_slot_reg <= s3_slot_reg;
        s4_grad_reg <= s3_grad_reg;

        for (int n = 2; n <= 5; n++)
        begin
            t_reg[n] <= t_reg[n-1];
        end
        for (int n = 4; n <= 13; n++)
        begin
            w_reg[n] <= w_reg[n-1];
        end

        s6_p_reg <= s6_p_next;
        s7_c_reg <= s7_c_next;
    end

    // ---------------------------------------------------------------- blends
    // x blends pair corners that differ only in x; their results feed the y
    // blends, whose results feed the single z blend.
    corner_t lx [4];
    corner_t ly [2];
    corner_t lz;

    for (genvar n = 0; n < 4; n++)
    begin : g_lerp_x
        pn3_lerp u_lerp (
            .clk (clk),
            .a   (s7_c_reg[2*n]),
            .b   (s7_c_reg[2*n+1]),
            .w   (w_reg[7][0]),
            .y   (lx[n])
        );
    end

    for (genvar n = 0; n < 2; n++)
    begin : g_lerp_y
        pn3_lerp u_lerp (
            .clk (clk),
            .a   (lx[2*n]),
            .b   (lx[2*n+1]),
            .w   (w_reg[10][1]),
            .y   (ly[n])
        );
    end

    pn3_lerp u_lerp_z (
        .clk (clk),
        .a   (ly[0]),
        .b   (ly[1]),
        .w   (w_reg[13][2]),
        .y   (lz)
    );

    // ---------------------------------------------------------------- output
    logic signed [CORNER_W-16:0] v_floor;
    logic signed [NOISE_W-1:0]   noise_next;
    logic signed [NOISE_W-1:0]   noise_value_reg;

    always_comb
    begin
        // Floor the Q.31 blend to Q.16 and clamp into the signed 18-bit word.
        v_floor = lz[CORNER_W-1:15];
        if (v_floor > (CORNER_W-15)'(131071))
        begin
            noise_next = NOISE_W'(131071);
        end
        else if (v_floor < -(CORNER_W-15)'(131072))
        begin
            noise_next = -NOISE_W'(131072);
        end
        else
        begin
            noise_next = v_floor[NOISE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_pipe_reg[LAST-1])
        begin
            noise_value_reg <= noise_next;
        end
    end

    assign noise_value = noise_value_reg;

`ifndef SYNTHESIS
    // Every evaluate request produces its word with done high.
    a_eval_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == REQ_EVAL) |-> ##17 done)
        else $error("evaluate request did not yield a word on time");

    // A load request never produces a word in its result slot.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == REQ_LOAD) |-> ##17 !done)
        else $error("load request produced a result word");

    // A table write and a table read for an evaluate never share the read stage.
    a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ld_pipe_reg[4] && ev_pipe_reg[4]))
        else $error("load and evaluate collided at the table stage");
`endif

endmodule

`default_nettype wire

// ===== verif/perlin_noise_3d_tb.sv =====
// Self-checking testbench of the 3D gradient noise evaluator with its loadable gradient table.
`timescale 1ns / 100ps
`default_nettype none

module perlin_noise_3d_tb;
    import pn3_pkg::*;

    // The block returns a word for each evaluate request that it takes.
    localparam int PIPE_LATENCY = 17;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 680;

    // Keeps its own copy of the gradient table and works out the noise value
    // of every evaluate request that the block takes. Noise values wait in a
    // queue, oldest first, until the block shows them.
    class noise_board;
        logic signed [15:0] grad_table [256][3];
        logic [NOISE_W-1:0] pending_noise [$];
        int                 errors;

        function new();
            errors = 0;
            foreach (grad_table[i, j])
                grad_table[i][j] = '0;
        endfunction

        // Smoothstep weight 3t^2 - 2t^3 in Q0.16, floored.
        function longint smooth_weight(longint t);
            longint unsigned u;
            u = t;
            return longint'((u * u * (64'd196608 - 64'd2 * u)) >> 32);
        endfunction

        // Linear blend with the weight applied to the difference, floored.
        function longint lerp_floor(longint w, longint a, longint b);
            return a + ((w * (b - a)) >>> 16);
        endfunction

        // Hashes the lattice corner through the permutation ROM and forms the
        // dot product of its gradient with the offset to the point.
        function longint corner_dot(logic [7:0] ix, logic [7:0] iy, logic [7:0] iz,
                                    longint fx, longint fy, longint fz);
            logic [7:0] hz;
            logic [7:0] hy;
            logic [7:0] h;
            hz = iy + PERM_ROM[iz];
            hy = ix + PERM_ROM[hz];
            h  = PERM_ROM[hy];
            return longint'(grad_table[h][0]) * fx + longint'(grad_table[h][1]) * fy
                 + longint'(grad_table[h][2]) * fz;
        endfunction

        function void note_request(logic req, logic [31:0] cx, logic [31:0] cy,
                                   logic [31:0] cz, logic [7:0] slot,
                                   logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
            logic [7:0] x0, y0, z0, x1, y1, z1;
            longint fx0, fy0, fz0, fx1, fy1, fz1, wx, wy, wz;
            longint a, b, near_z, far_z, v;
            if (req == REQ_LOAD)
            begin
                grad_table[slot][0] = gx;
                grad_table[slot][1] = gy;
                grad_table[slot][2] = gz;
                return;
            end
            // Lattice index wraps modulo the table size, so only bits 23:16 matter.
            x0 = cx[23:16];
            y0 = cy[23:16];
            z0 = cz[23:16];
            x1 = x0 + 8'd1;
            y1 = y0 + 8'd1;
            z1 = z0 + 8'd1;
            fx0 = longint'(cx[15:0]);
            fy0 = longint'(cy[15:0]);
            fz0 = longint'(cz[15:0]);
            fx1 = fx0 - 65536;
            fy1 = fy0 - 65536;
            fz1 = fz0 - 65536;
            wx = smooth_weight(fx0);
            wy = smooth_weight(fy0);
            wz = smooth_weight(fz0);
            a = lerp_floor(wx, corner_dot(x0, y0, z0, fx0, fy0, fz0),
                               corner_dot(x1, y0, z0, fx1, fy0, fz0));
            b = lerp_floor(wx, corner_dot(x0, y1, z0, fx0, fy1, fz0),
                               corner_dot(x1, y1, z0, fx1, fy1, fz0));
            near_z = lerp_floor(wy, a, b);
            a = lerp_floor(wx, corner_dot(x0, y0, z1, fx0, fy0, fz1),
                               corner_dot(x1, y0, z1, fx1, fy0, fz1));
            b = lerp_floor(wx, corner_dot(x0, y1, z1, fx0, fy1, fz1),
                               corner_dot(x1, y1, z1, fx1, fy1, fz1));
            far_z = lerp_floor(wy, a, b);
            // Q.31 down to Q.16 by floor, then saturate to the 18-bit word.
            v = lerp_floor(wz, near_z, far_z) >>> 15;
            if (v > 131071)
                v = 131071;
            if (v < -131072)
                v = -131072;
            pending_noise.push_back(v[NOISE_W-1:0]);
        endfunction

        function void check_noise(logic [NOISE_W-1:0] actual);
            logic [NOISE_W-1:0] want;
            if (pending_noise.size() == 0)
            begin
                $error("noise_value: expected no word, actual %0d", $signed(actual));
                errors++;
                return;
            end
            want = pending_noise.pop_front();
            if (actual !== want)
            begin
                $error("noise_value: expected %0d, actual %0d", $signed(want), $signed(actual));
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     req_type;
    logic signed [31:0]       coord_x;
    logic signed [31:0]       coord_y;
    logic signed [31:0]       coord_z;
    logic [7:0]               grad_slot;
    logic signed [15:0]       grad_x;
    logic signed [15:0]       grad_y;
    logic signed [15:0]       grad_z;
    logic                     done;
    logic signed [NOISE_W-1:0] noise_value;

    noise_board board = new();
    int         cycle_count = 0;
    // Chance in percent of idle cycles ahead of a word, set per phase.
    int         idle_pct;

    perlin_noise_3d DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .grad_slot  (grad_slot),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .grad_z     (grad_z),
        .done       (done),
        .noise_value(noise_value)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Requests are taken at an edge with start high and busy low; a noise word
    // is valid for exactly the one cycle in which done is high. Both are
    // sampled at the edge, before any driver update of that edge lands.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_request(req_type, coord_x, coord_y, coord_z,
                                   grad_slot, grad_x, grad_y, grad_z);
            if (done)
                board.check_noise(noise_value);
        end
    end

    // Presents one word and holds it until the block takes it. Idle cycles are
    // inserted ahead of the word according to the current phase.
    task automatic send_word(logic req, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [7:0] slot, logic [15:0] gx, logic [15:0] gy,
                             logic [15:0] gz);
        int gap;
        gap = 0;
        if (idle_pct >= 80)
            gap = $urandom_range(0, 8);
        else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 2);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        req_type  <= req;
        coord_x   <= cx;
        coord_y   <= cy;
        coord_z   <= cz;
        grad_slot <= slot;
        grad_x    <= gx;
        grad_y    <= gy;
        grad_z    <= gz;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic load_gradient(logic [7:0] slot, logic [15:0] gx, logic [15:0] gy,
                                 logic [15:0] gz);
        send_word(REQ_LOAD, $urandom, $urandom, $urandom, slot, gx, gy, gz);
    endtask

    task automatic eval_point(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
        send_word(REQ_EVAL, cx, cy, cz, 8'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    endtask

    // Gradient component: mostly random, sometimes a full-scale extreme.
    function automatic logic [15:0] pick_grad();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Coordinate: a mix of full 32-bit patterns and points near the origin with
    // fractions on the lattice, just past it, at the middle, just short of one or random.
    function automatic logic [31:0] pick_coord();
        logic [15:0] whole;
        logic [15:0] frac;
        if ($urandom_range(0, 99) < 55)
            return $urandom;
        whole = $urandom_range(0, 1) ? 16'($urandom_range(0, 4)) : -16'($urandom_range(1, 4));
        case ($urandom_range(0, 4))
            0: frac = 16'h0000;
            1: frac = 16'h8000;
            2: frac = 16'hFFFF;
            3: frac = 16'h0001;
            default: frac = 16'($urandom);
        endcase
        return {whole, frac};
    endfunction

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_EVAL;
        coord_x     = '0;
        coord_y     = '0;
        coord_z     = '0;
        grad_slot   = '0;
        grad_x      = '0;
        grad_y      = '0;
        grad_z      = '0;
        idle_pct    = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The table holds nothing defined after reset, so every entry is loaded
        // before the first evaluate. Slots 0 and 255 get the full-scale extremes.
        for (int s = 0; s < 256; s++)
        begin
            if (s == 0)
                load_gradient(8'(s), 16'h7FFF, 16'h7FFF, 16'h7FFF);
            else if (s == 255)
                load_gradient(8'(s), 16'h8000, 16'h8000, 16'h8000);
            else
                load_gradient(8'(s), pick_grad(), pick_grad(), pick_grad());
        end

        // Directed points: origin, lattice corners, mid-cell, fractions just
        // short of one, and coordinate extremes where the index wraps.
        eval_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        eval_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        eval_point(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
        eval_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        eval_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        eval_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        eval_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        eval_point(32'h80FF_4000, 32'h7F00_C000, 32'h00FF_0001);
        eval_point(32'h00FF_8000, 32'hFF00_8000, 32'h0000_FFFF);
        // A load right in front of an evaluate that uses the same slot must be
        // seen by that evaluate. Slot 36 holds the gradient of the origin corner
        // of the cell at the origin.
        load_gradient(8'd36, 16'h7FFF, 16'h8000, 16'h7FFF);
        eval_point(32'h0000_4000, 32'h0000_C000, 32'h0000_2000);
        for (int k = 0; k < 6; k++)
            eval_point(pick_coord(), pick_coord(), pick_coord());

        // Random words over the idling phases; about one in five reloads a
        // gradient entry, so later evaluates see changed entries.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 80;
                2: idle_pct = 0;
                default: idle_pct = 34;
            endcase
            for (int n = 0; n < RANDOM_WORDS / 4; n++)
            begin
                if ($urandom_range(0, 99) < 20)
                    load_gradient(8'($urandom), pick_grad(), pick_grad(), pick_grad());
                else
                    eval_point(pick_coord(), pick_coord(), pick_coord());
            end
        end
        start <= 1'b0;

        while (board.pending_noise.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);

        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
